FILE: design/zobrist_board_hash_pair_macros.svh
// ----------------------------------------------------------------------------
// zobrist_board_hash_pair_macros
// Assertion macros shared by the hash block. Define NO_ASSERTIONS to drop them.
// ----------------------------------------------------------------------------
`ifndef ZOBRIST_BOARD_HASH_PAIR_MACROS_SVH
`define ZOBRIST_BOARD_HASH_PAIR_MACROS_SVH
`ifndef NO_ASSERTIONS
// property on the module's own clk and rst
`define ZBH_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// property on an explicit clock and reset
`define ZBH_ASSERT_CLK(label, clock, reset, prop, msg) \
  label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`else
`define ZBH_ASSERT(label, prop, msg)
`define ZBH_ASSERT_CLK(label, clock, reset, prop, msg)
`endif
`endif

FILE: design/zbh_pkg.sv
// ----------------------------------------------------------------------------
// zbh_pkg
// Types, constants and helpers for the dual 32-bit board hash block.
// ----------------------------------------------------------------------------
`default_nettype none

package zbh_pkg;

  localparam int DEF_SQUARE_COUNT = 90;
  localparam int DEF_DIGIT_BASE   = 256;
  localparam int DEF_ENTRY_COUNT  = 256;
  localparam int DEF_CODE_WIDTH   = 64;

  localparam logic [31:0] SEED_WORD = 32'h9E3779B9;
  localparam int KIND_COUNT   = 14;
  localparam int BLACK_OFFSET = 7;
  localparam int SHIFT_A = 13;
  localparam int SHIFT_B = 17;
  localparam int SHIFT_C = 5;

  typedef struct packed {
    logic        piece_present;
    logic [2:0]  piece_type;
    logic        piece_color;
    logic [6:0]  square;
    logic [63:0] check_code_red;
    logic [63:0] check_code_black;
    logic        last;
  } zbh_in_t;

  typedef struct packed {
    logic [31:0] hash_first;
    logic [31:0] hash_second;
  } zbh_out_t;

  typedef enum logic [2:0] {
    ST_FILL,
    ST_IDLE,
    ST_MIX_RED,
    ST_MIX_BLACK,
    ST_DONE
  } zbh_state_t;

  typedef struct packed {
    logic fill;        // advance the key generator and table fill
    logic accept;      // capture a board item
    logic walk;        // take the next check-code digit
    logic sel_black;   // digits belong to the black tables
    logic load_black;  // switch the digit walk to the black code
    logic emit;        // present the hash pair
  } zbh_cmd_t;

  typedef struct packed {
    logic fill_done;
    logic code_zero;
  } zbh_sts_t;

  function automatic logic [31:0] xorshift32(input logic [31:0] s);
    logic [31:0] a;
    logic [31:0] b;
    a = s ^ (s << SHIFT_A);
    b = a ^ (a >> SHIFT_B);
    return b ^ (b << SHIFT_C);
  endfunction

  // kind within a color: soldier, horse, chariot, cannon, elephant, advisor, king
  function automatic logic [3:0] kind_map(input logic [2:0] piece_type);
    logic [3:0] k;
    unique case (piece_type)
      3'd1:    k = 4'd0;
      3'd2:    k = 4'd1;
      3'd3:    k = 4'd2;
      3'd4:    k = 4'd3;
      3'd5:    k = 4'd5;
      3'd6:    k = 4'd4;
      3'd7:    k = 4'd6;
      default: k = 4'd0;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

FILE: design/zbh_ram.sv
// ----------------------------------------------------------------------------
// zbh_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module zbh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: design/zbh_datapath.sv
// ----------------------------------------------------------------------------
// zbh_datapath
// Key generator and table fill, piece lookup, check-code digit walk and the
// running hash pair.
// ----------------------------------------------------------------------------
`default_nettype none

module zbh_datapath #(
  parameter int SQUARE_COUNT = zbh_pkg::DEF_SQUARE_COUNT,
  parameter int DIGIT_BASE   = zbh_pkg::DEF_DIGIT_BASE,
  parameter int ENTRY_COUNT  = zbh_pkg::DEF_ENTRY_COUNT,
  parameter int CODE_WIDTH   = zbh_pkg::DEF_CODE_WIDTH
) (
  input  logic              clk,
  input  logic              rst,
  input  zbh_pkg::zbh_cmd_t cmd,
  output zbh_pkg::zbh_sts_t sts,
  input  zbh_pkg::zbh_in_t  item,
  output zbh_pkg::zbh_out_t result,
  output logic              done
);
  import zbh_pkg::*;

  localparam int PieceEntries = KIND_COUNT * SQUARE_COUNT;
  localparam int PAW = $clog2(PieceEntries);
  localparam int CAW = $clog2(ENTRY_COUNT);
  localparam int FW  = $clog2(PieceEntries > ENTRY_COUNT ? PieceEntries : ENTRY_COUNT);
  localparam int DW  = $clog2(DIGIT_BASE);
  localparam bit BasePow2 = (DIGIT_BASE == (1 << DW));

  // ---------------- table fill ----------------
  logic [31:0]   gen;
  logic [31:0]   gen_next;
  logic [31:0]   held;
  logic [1:0]    phase;
  logic          fill_chk;
  logic [FW-1:0] fill_idx;
  logic          piece_we;
  logic          red_we;
  logic          black_we;
  logic [63:0]   fill_word;

  assign gen_next  = xorshift32(gen);
  assign fill_word = {held, gen_next};
  assign piece_we  = cmd.fill && !fill_chk && phase[0];
  assign red_we    = cmd.fill && fill_chk && (phase == 2'd1);
  assign black_we  = cmd.fill && fill_chk && (phase == 2'd3);
  assign sts.fill_done = fill_chk && (phase == 2'd3) && (fill_idx == FW'(ENTRY_COUNT - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      gen      <= SEED_WORD;
      phase    <= 2'd0;
      fill_chk <= 1'b0;
      fill_idx <= '0;
    end else if (cmd.fill) begin
      gen <= gen_next;
      if (!fill_chk) begin
        phase <= {1'b0, ~phase[0]};
        if (phase[0]) begin
          if (fill_idx == FW'(PieceEntries - 1)) begin
            fill_chk <= 1'b1;
            fill_idx <= FW'(1);  // check entry 0 stays unused
          end else begin
            fill_idx <= fill_idx + FW'(1);
          end
        end
      end else begin
        phase <= phase + 2'd1;
        if (phase == 2'd3) begin
          fill_idx <= fill_idx + FW'(1);
        end
      end
    end
  end

  // first word of each pair waits here for its partner
  always_ff @(posedge clk) begin
    if (cmd.fill && !phase[0]) begin
      held <= gen_next;
    end
  end

  // ---------------- piece lookup ----------------
  logic [3:0]  kind;
  logic [11:0] piece_idx;
  logic        piece_ok;
  logic [63:0] piece_q;

  assign kind      = kind_map(item.piece_type) + (item.piece_color ? 4'(BLACK_OFFSET) : 4'd0);
  assign piece_idx = 12'(kind) * 12'(SQUARE_COUNT) + 12'(item.square);
  assign piece_ok  = item.piece_present && (item.piece_type != 3'd0) &&
                     (9'(item.square) < 9'(SQUARE_COUNT));

  zbh_ram #(.WIDTH(64), .DEPTH(PieceEntries)) u_piece_ram (
    .clk   (clk),
    .we    (piece_we),
    .waddr (fill_idx[PAW-1:0]),
    .wdata (fill_word),
    .raddr (piece_idx[PAW-1:0]),
    .rdata (piece_q)
  );

  // ---------------- check-code digit walk ----------------
  logic [CODE_WIDTH-1:0] code;
  logic [CODE_WIDTH-1:0] black_code;
  logic [CODE_WIDTH-1:0] quot;
  logic [CODE_WIDTH-1:0] load_val;
  logic                  load_en;
  logic [DW-1:0]         digit;
  logic                  dig_ready;
  logic                  digit_ok;
  logic                  take;
  logic [CAW-1:0]        chk_addr;
  logic [63:0]           red_q;
  logic [63:0]           black_q;

  assign load_en  = cmd.accept || cmd.load_black;
  assign load_val = cmd.accept ? CODE_WIDTH'(item.check_code_red) : black_code;
  assign digit_ok = (digit != '0) && (13'(digit) < 13'(ENTRY_COUNT));
  assign chk_addr = CAW'(digit);
  assign take     = cmd.walk && dig_ready;
  assign sts.code_zero = (code == '0);

  generate
    if (BasePow2) begin : g_shift
      localparam int XW = CODE_WIDTH > DW ? CODE_WIDTH : DW;
      logic [XW-1:0] code_x;
      assign code_x    = XW'(code);
      assign digit     = code_x[DW-1:0];
      assign quot      = CODE_WIDTH'(code_x >> DW);
      assign dig_ready = 1'b1;
    end else begin : g_recip
      // long division by the constant base, CHUNK dividend bits a cycle while walk is held;
      // each chunk quotient is a multiply by the base's scaled reciprocal
      localparam int CHUNK = 16;
      localparam int STEPS = (CODE_WIDTH + CHUNK - 1) / CHUNK;
      localparam int PW    = STEPS * CHUNK;
      localparam int NW    = DW + CHUNK;
      localparam int SH    = NW + DW;
      localparam logic [63:0] RECIP =
        ((64'd1 << SH) + 64'(DIGIT_BASE) - 64'd1) / 64'(DIGIT_BASE);
      localparam int CNTW  = $clog2(STEPS + 1);
      logic [PW-1:0]    dvd;
      logic [PW-1:0]    quo;
      logic [DW-1:0]    rem;
      logic [CNTW-1:0]  cnt;
      logic [NW-1:0]    part;
      logic [2*NW:0]    prod;
      logic [CHUNK-1:0] qc;
      logic [NW-1:0]    rest;

      assign part      = {rem, dvd[PW-1 -: CHUNK]};
      assign prod      = (2*NW+1)'(part) * (2*NW+1)'(RECIP[NW:0]);
      assign qc        = prod[SH +: CHUNK];
      assign rest      = part - NW'(qc) * NW'(DIGIT_BASE);
      assign dig_ready = (cnt == CNTW'(STEPS));
      assign digit     = rem;
      assign quot      = CODE_WIDTH'(quo);

      always_ff @(posedge clk) begin
        if (load_en) begin
          dvd <= PW'(load_val);
          quo <= '0;
          rem <= '0;
          cnt <= '0;
        end else if (cmd.walk) begin
          if (!dig_ready) begin
            dvd <= dvd << CHUNK;
            quo <= PW'({quo, qc});
            rem <= DW'(rest);
            cnt <= cnt + CNTW'(1);
          end else begin
            // quotient becomes the next dividend
            dvd <= quo;
            quo <= '0;
            rem <= '0;
            cnt <= '0;
          end
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (load_en) begin
      code <= load_val;
    end else if (take) begin
      code <= quot;
    end
    if (cmd.accept) begin
      black_code <= CODE_WIDTH'(item.check_code_black);
    end
  end

  zbh_ram #(.WIDTH(64), .DEPTH(ENTRY_COUNT)) u_red_ram (
    .clk   (clk),
    .we    (red_we),
    .waddr (fill_idx[CAW-1:0]),
    .wdata (fill_word),
    .raddr (chk_addr),
    .rdata (red_q)
  );

  zbh_ram #(.WIDTH(64), .DEPTH(ENTRY_COUNT)) u_black_ram (
    .clk   (clk),
    .we    (black_we),
    .waddr (fill_idx[CAW-1:0]),
    .wdata (fill_word),
    .raddr (chk_addr),
    .rdata (black_q)
  );

  // ---------------- running hash pair ----------------
  logic        pend_piece;
  logic        pend_red;
  logic        pend_black;
  logic [63:0] running;
  logic [63:0] running_next;

  // RAM data lands the cycle after the read, folded in here
  assign running_next = running ^ (pend_piece ? piece_q : 64'd0)
                                ^ (pend_red   ? red_q   : 64'd0)
                                ^ (pend_black ? black_q : 64'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_piece <= 1'b0;
      pend_red   <= 1'b0;
      pend_black <= 1'b0;
      running    <= '0;
      done       <= 1'b0;
    end else begin
      pend_piece <= cmd.accept && piece_ok;
      pend_red   <= take && digit_ok && !cmd.sel_black;
      pend_black <= take && digit_ok && cmd.sel_black;
      running    <= cmd.emit ? 64'd0 : running_next;
      done       <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result.hash_first  <= running_next[63:32];
      result.hash_second <= running_next[31:0];
    end
  end

endmodule

`default_nettype wire

FILE: design/zbh_ctrl.sv
// ----------------------------------------------------------------------------
// zbh_ctrl
// Sequencer: table fill after reset, item intake, red then black digit walk,
// result emission.
// ----------------------------------------------------------------------------
`default_nettype none

module zbh_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              last,
  input  zbh_pkg::zbh_sts_t sts,
  output zbh_pkg::zbh_cmd_t cmd,
  output logic              busy
);
  import zbh_pkg::*;

  zbh_state_t state;
  zbh_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_FILL;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    unique case (state)
      ST_FILL: begin
        cmd.fill = 1'b1;
        if (sts.fill_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.accept = 1'b1;
          if (last) begin
            state_next = ST_MIX_RED;
          end
        end
      end
      ST_MIX_RED: begin
        if (sts.code_zero) begin
          cmd.load_black = 1'b1;
          state_next     = ST_MIX_BLACK;
        end else begin
          cmd.walk = 1'b1;
        end
      end
      ST_MIX_BLACK: begin
        cmd.sel_black = 1'b1;
        if (sts.code_zero) begin
          state_next = ST_DONE;
        end else begin
          cmd.walk = 1'b1;
        end
      end
      ST_DONE: begin
        cmd.emit   = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_FILL;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: design/zobrist_board_hash_pair.sv
// ----------------------------------------------------------------------------
// zobrist_board_hash_pair
// Dual 32-bit Zobrist hash of a board, with check-state digits mixed in on
// the last item of each board.
//
//   channel | ports               | transaction
//   --------+---------------------+--------------------------------------
//   item    | start, busy, item   | start high while busy low
//   result  | done, result        | done high for one cycle, no back-pressure
//
// After reset the key tables are filled, two words per piece entry and four
// per check entry, one generator step a cycle, with busy high.
// An item without last is taken while the block stays idle; the next can
// follow at once. A last item has the red code walked one digit at a time
// up to its top nonzero digit, then the black code, each digit coming from a
// 16-bit-chunk long division when DIGIT_BASE is not a power of two; the
// hash pair is then emitted and done follows the busy period.
// ----------------------------------------------------------------------------
`default_nettype none
`include "zobrist_board_hash_pair_macros.svh"

module zobrist_board_hash_pair #(
  parameter int SQUARE_COUNT = zbh_pkg::DEF_SQUARE_COUNT,
  parameter int DIGIT_BASE   = zbh_pkg::DEF_DIGIT_BASE,
  parameter int ENTRY_COUNT  = zbh_pkg::DEF_ENTRY_COUNT,
  parameter int CODE_WIDTH   = zbh_pkg::DEF_CODE_WIDTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  zbh_pkg::zbh_in_t  item,
  output logic              done,
  output zbh_pkg::zbh_out_t result
);
  import zbh_pkg::*;

  zbh_cmd_t cmd;
  zbh_sts_t sts;

  zbh_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .last  (item.last),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  zbh_datapath #(
    .SQUARE_COUNT (SQUARE_COUNT),
    .DIGIT_BASE   (DIGIT_BASE),
    .ENTRY_COUNT  (ENTRY_COUNT),
    .CODE_WIDTH   (CODE_WIDTH)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .sts    (sts),
    .item   (item),
    .result (result),
    .done   (done)
  );

  `ZBH_ASSERT(a_done_single, done |=> !done, "two results in consecutive cycles")
  `ZBH_ASSERT(a_done_after_busy, done |-> $past(busy), "result without a busy period")
  `ZBH_ASSERT(a_plain_item, start && !busy && !item.last |=> !busy, "plain item stalled intake")
  `ZBH_ASSERT_CLK(a_last_busy, clk, rst, start && !busy && item.last |=> busy, "last item not held")

endmodule

`default_nettype wire

FILE: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the dual 32-bit board hash. A tracker keeps its
// own key tables and running hashes, predicts the hash pair of every board
// and checks each result in order. Directed boards cover every piece kind,
// the ignored items and the check-code corners; random boards with random
// gaps, quiet stretches and drain pauses follow.
// ----------------------------------------------------------------------------

class zobrist_pair_tracker;
  localparam int SQUARE_COUNT  = zbh_pkg::DEF_SQUARE_COUNT;
  localparam int DIGIT_BASE    = zbh_pkg::DEF_DIGIT_BASE;
  localparam int ENTRY_COUNT   = zbh_pkg::DEF_ENTRY_COUNT;
  localparam int CODE_WIDTH    = zbh_pkg::DEF_CODE_WIDTH;
  localparam int PIECE_ENTRIES = 14 * SQUARE_COUNT;
  localparam bit [63:0] CODE_MASK =
    (CODE_WIDTH >= 64) ? {64{1'b1}} : ((64'd1 << CODE_WIDTH) - 64'd1);
  localparam bit [31:0] SEED = 32'h9E3779B9;

  bit [31:0] piece_first [PIECE_ENTRIES];
  bit [31:0] piece_second [PIECE_ENTRIES];
  bit [31:0] red_first [ENTRY_COUNT];
  bit [31:0] red_second [ENTRY_COUNT];
  bit [31:0] black_first [ENTRY_COUNT];
  bit [31:0] black_second [ENTRY_COUNT];
  bit [31:0] run_first;
  bit [31:0] run_second;
  zbh_pkg::zbh_out_t pending [$];
  int mismatch_count;

  static function bit [31:0] next_word(bit [31:0] s);
    s = s ^ (s << 13);
    s = s ^ (s >> 17);
    s = s ^ (s << 5);
    return s;
  endfunction

  function new();
    bit [31:0] w;
    w = SEED;
    for (int i = 0; i < PIECE_ENTRIES; i++) begin
      w = next_word(w);
      piece_first[i] = w;
      w = next_word(w);
      piece_second[i] = w;
    end
    red_first[0] = '0;
    red_second[0] = '0;
    black_first[0] = '0;
    black_second[0] = '0;
    for (int i = 1; i < ENTRY_COUNT; i++) begin
      w = next_word(w);
      red_first[i] = w;
      w = next_word(w);
      red_second[i] = w;
      w = next_word(w);
      black_first[i] = w;
      w = next_word(w);
      black_second[i] = w;
    end
    run_first = '0;
    run_second = '0;
    mismatch_count = 0;
  endfunction

  // table row of a piece: kinds within a color, black rows after red
  function int kind_row(bit [2:0] kind, bit side);
    int k;
    case (kind)
      3'd1:    k = 0;
      3'd2:    k = 1;
      3'd3:    k = 2;
      3'd4:    k = 3;
      3'd5:    k = 5;
      3'd6:    k = 4;
      3'd7:    k = 6;
      default: k = 0;
    endcase
    return side ? k + 7 : k;
  endfunction

  // walk digits from the least significant one, skip zero digits
  function void fold_code(bit [63:0] code, bit side, inout bit [31:0] h1,
                          inout bit [31:0] h2);
    bit [63:0] digit;
    while (code != 0) begin
      digit = code % DIGIT_BASE;
      code = code / DIGIT_BASE;
      if (digit != 0 && digit < ENTRY_COUNT) begin
        if (side) begin
          h1 ^= black_first[digit];
          h2 ^= black_second[digit];
        end else begin
          h1 ^= red_first[digit];
          h2 ^= red_second[digit];
        end
      end
    end
  endfunction

  function void take_item(zbh_pkg::zbh_in_t x);
    int slot;
    bit [31:0] h1;
    bit [31:0] h2;
    bit [63:0] red;
    bit [63:0] blk;
    zbh_pkg::zbh_out_t pair;
    if (x.piece_present && x.piece_type != 0 && x.square < SQUARE_COUNT) begin
      slot = kind_row(x.piece_type, x.piece_color) * SQUARE_COUNT + x.square;
      if (slot < PIECE_ENTRIES) begin
        run_first ^= piece_first[slot];
        run_second ^= piece_second[slot];
      end
    end
    if (!x.last) return;
    h1 = run_first;
    h2 = run_second;
    red = x.check_code_red & CODE_MASK;
    blk = x.check_code_black & CODE_MASK;
    if (red != 0 || blk != 0) begin
      fold_code(red, 1'b0, h1, h2);
      fold_code(blk, 1'b1, h1, h2);
    end
    pair.hash_first = h1;
    pair.hash_second = h2;
    pending.push_back(pair);
    run_first = '0;
    run_second = '0;
  endfunction

  task report(string msg);
    $display("ERROR @%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task check_pair(zbh_pkg::zbh_out_t r);
    zbh_pkg::zbh_out_t e;
    if (pending.size() == 0) begin
      report($sformatf("result %h/%h with no board pending", r.hash_first,
                       r.hash_second));
      return;
    end
    e = pending.pop_front();
    if (r.hash_first !== e.hash_first)
      report($sformatf("hash_first %h, want %h", r.hash_first, e.hash_first));
    if (r.hash_second !== e.hash_second)
      report($sformatf("hash_second %h, want %h", r.hash_second, e.hash_second));
  endtask
endclass

module testbench;
  import zbh_pkg::*;

  localparam int LIMIT_CYCLES = 300000;
  localparam int ITEM_TARGET  = 1100;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  zbh_in_t  item = '0;
  logic     busy;
  logic     done;
  zbh_out_t result;

  zobrist_pair_tracker tracker = new();
  int items_sent = 0;
  int calm_left = 0;

  zobrist_board_hash_pair dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .done   (done),
    .result (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && done) tracker.check_pair(result);
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic zbh_in_t make_item(bit pres, bit [2:0] kind, bit side,
                                        bit [6:0] sq, bit [63:0] red,
                                        bit [63:0] blk, bit fin);
    zbh_in_t x;
    x.piece_present = pres;
    x.piece_type = kind;
    x.piece_color = side;
    x.square = sq;
    x.check_code_red = red;
    x.check_code_black = blk;
    x.last = fin;
    return x;
  endfunction

  function automatic bit [63:0] draw_code();
    bit [63:0] c;
    c = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: c = '0;
      1: c = {56'd0, c[7:0]};
      2: ;
      3: c = '1;
      4: begin
        for (int i = 0; i < 8; i++)
          if ($urandom_range(0, 1)) c[i*8 +: 8] = 8'd0;
      end
      default: c = c >> $urandom_range(1, 63);
    endcase
    return c;
  endfunction

  // start stays high across back-to-back transactions
  task automatic send_item(input zbh_in_t x);
    int gap;
    zbh_in_t junk;
    if (calm_left > 0) begin
      calm_left--;
      gap = 0;
    end else if ($urandom_range(0, 24) == 0) begin
      calm_left = $urandom_range(8, 40);
      gap = 0;
    end else begin
      gap = $urandom_range(0, 16);
    end
    if (gap > 0) begin
      junk.check_code_red = {$urandom, $urandom};
      junk.check_code_black = {$urandom, $urandom};
      {junk.piece_present, junk.piece_type, junk.piece_color, junk.square,
       junk.last} = 13'($urandom);
      start <= 1'b0;
      item <= junk;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    item <= x;
    do @(posedge clk); while (busy);
    tracker.take_item(x);
    items_sent++;
  endtask

  task automatic send_board();
    int pieces;
    zbh_in_t x;
    pieces = ($urandom_range(0, 9) == 0) ? $urandom_range(24, 32) : $urandom_range(0, 14);
    repeat (pieces) begin
      if ($urandom_range(0, 9) == 0)
        x = make_item(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                      1'($urandom_range(0, 1)), 7'($urandom_range(0, 127)),
                      {$urandom, $urandom}, {$urandom, $urandom}, 1'b0);
      else
        x = make_item(1'b1, 3'($urandom_range(1, 7)), 1'($urandom_range(0, 1)),
                      7'($urandom_range(0, 89)), {$urandom, $urandom},
                      {$urandom, $urandom}, 1'b0);
      send_item(x);
    end
    x = make_item(1'($urandom_range(0, 1)), 3'($urandom_range(1, 7)),
                  1'($urandom_range(0, 1)), 7'($urandom_range(0, 89)),
                  draw_code(), draw_code(), 1'b1);
    if ($urandom_range(0, 7) == 0) begin
      x.check_code_red = '0;
      x.check_code_black = '0;
    end
    send_item(x);
  endtask

  initial begin
    int boards;
    boards = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // corner items, then an empty board
    send_item(make_item(1'b1, 3'd1, 1'b0, 7'd0, '1, '1, 1'b0));
    send_item(make_item(1'b1, 3'd7, 1'b1, 7'd89, '0, '0, 1'b0));
    send_item(make_item(1'b1, 3'd0, 1'b0, 7'd5, '0, '0, 1'b0));
    send_item(make_item(1'b1, 3'd4, 1'b0, 7'd90, '0, '0, 1'b0));
    send_item(make_item(1'b1, 3'd5, 1'b1, 7'd127, '0, '0, 1'b0));
    send_item(make_item(1'b0, 3'd6, 1'b0, 7'd3, '0, '0, 1'b0));
    send_item(make_item(1'b0, 3'd0, 1'b0, 7'd0, '0, '0, 1'b1));
    send_item(make_item(1'b0, 3'd0, 1'b0, 7'd0, '0, '0, 1'b1));
    // every kind on both sides
    for (int k = 1; k <= 7; k++)
      for (int s = 0; s < 2; s++)
        send_item(make_item(1'b1, 3'(k), 1'(s), 7'($urandom_range(0, 89)), '0, '0, 1'b0));
    send_item(make_item(1'b1, 3'd3, 1'b1, 7'd10, '1, '1, 1'b1));
    send_item(make_item(1'b1, 3'd6, 1'b1, 7'd88, 64'h0100_0000_0000_00FF, '0, 1'b1));
    send_item(make_item(1'b0, 3'd2, 1'b0, 7'd1, '0, 64'h8000_0000_0000_0001, 1'b1));

    while (items_sent < ITEM_TARGET) begin
      send_board();
      boards++;
      if (boards % 10 == 0) begin
        // hold off until the pipeline is empty
        start <= 1'b0;
        do @(posedge clk); while (tracker.pending.size() != 0);
      end
    end

    start <= 1'b0;
    do @(posedge clk); while (tracker.pending.size() != 0);
    repeat (48) @(posedge clk);
    if (tracker.pending.size() != 0)
      tracker.report($sformatf("%0d boards never reported", tracker.pending.size()));
    if (tracker.mismatch_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule
